### hw/rtl/toroidal_life_generation_step_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the life-board RTL (tlgs_ctrl).
// Both expect signals named clock and reset in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef TOROIDAL_LIFE_GENERATION_STEP_CORE_ASSERT_SVH
`define TOROIDAL_LIFE_GENERATION_STEP_CORE_ASSERT_SVH

// same-cycle implication
`define TLGS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tlgs assertion failed");

// next-cycle implication
`define TLGS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tlgs assertion failed");

`endif

### hw/rtl/tlgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlgs_pkg
// Shared types and constants of the toroidal life board core.
// ----------------------------------------------------------------------------
package tlgs_pkg;

   localparam int BOARD_WIDTH_DEFAULT  = 64;
   localparam int BOARD_HEIGHT_DEFAULT = 64;

   localparam int KIND_BITS     = 2;
   localparam int COORD_BITS    = 6;
   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = 8;

   // Conway rule counts
   localparam logic [3:0] KEEP_COUNT  = 4'd2;
   localparam logic [3:0] BIRTH_COUNT = 4'd3;

   typedef enum logic [KIND_BITS-1:0] {
      CMD_WRITE = 2'd0,
      CMD_STEP  = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      WR_ZERO    = 2'd0,
      WR_CELL    = 2'd1,
      WR_GEN_RAM = 2'd2,
      WR_GEN_TOP = 2'd3
   } wr_sel_type;

   typedef struct packed {
      logic       capture;
      logic       rd_en;
      logic       rd_item;
      logic       wr_en;
      logic       wr_item;
      wr_sel_type wr_sel;
      logic       load_above;
      logic       load_cur;
      logic       shift;
      logic       take_cell;
      logic       load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic                 on_board;
   } dp_status_type;

endpackage

### hw/rtl/tlgs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlgs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlgs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic                rd_en,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [WIDTH-1:0]    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tlgs_ctrl.sv
`timescale 1ns / 1ps
`include "toroidal_life_generation_step_core_assert.svh"
// ----------------------------------------------------------------------------
// tlgs_ctrl
// Sequencer: clearing pass, cell read-modify-write and the generation sweep.
// ----------------------------------------------------------------------------
module tlgs_ctrl #(
   parameter int BOARD_HEIGHT = tlgs_pkg::BOARD_HEIGHT_DEFAULT,
   localparam int RowBits = $clog2(BOARD_HEIGHT)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  tlgs_pkg::dp_status_type dp_status,
   output tlgs_pkg::dp_cmd_type    dp_cmd,
   output logic [RowBits-1:0]      rd_row,
   output logic [RowBits-1:0]      wr_row
);
   import tlgs_pkg::*;

   localparam logic [RowBits-1:0] LastRow   = RowBits'(BOARD_HEIGHT - 1);
   localparam logic [RowBits-1:0] PenultRow = RowBits'(BOARD_HEIGHT - 2);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_CELL_RD,
      ST_CELL_ACT,
      ST_G_PRIME,
      ST_G_ABOVE,
      ST_G_CUR,
      ST_G_SWEEP,
      ST_G_LAST,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic [RowBits-1:0] rd_ff;
   logic [RowBits-1:0] wr_ff;
   logic               rsp_tvalid_ff;

   always_comb begin
      dp_cmd     = '0;
      req_tready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_CLEAR: begin
            dp_cmd.wr_en  = 1'b1;
            dp_cmd.wr_sel = WR_ZERO;
         end
         ST_IDLE: begin
            dp_cmd.capture = req_tvalid;
         end
         ST_DISPATCH: begin
         end
         ST_CELL_RD: begin
            dp_cmd.rd_en   = 1'b1;
            dp_cmd.rd_item = 1'b1;
         end
         ST_CELL_ACT: begin
            dp_cmd.wr_en     = (dp_status.kind == CMD_WRITE) && dp_status.on_board;
            dp_cmd.wr_item   = 1'b1;
            dp_cmd.wr_sel    = WR_CELL;
            dp_cmd.take_cell = 1'b1;
         end
         ST_G_PRIME: begin
            dp_cmd.rd_en = 1'b1;
         end
         ST_G_ABOVE: begin
            dp_cmd.rd_en      = 1'b1;
            dp_cmd.load_above = 1'b1;
         end
         ST_G_CUR: begin
            dp_cmd.rd_en    = 1'b1;
            dp_cmd.load_cur = 1'b1;
         end
         ST_G_SWEEP: begin
            // no read once the last row is already in the read register
            dp_cmd.rd_en  = (wr_ff != PenultRow);
            dp_cmd.wr_en  = 1'b1;
            dp_cmd.wr_sel = WR_GEN_RAM;
            dp_cmd.shift  = 1'b1;
         end
         ST_G_LAST: begin
            dp_cmd.wr_en  = 1'b1;
            dp_cmd.wr_sel = WR_GEN_TOP;
         end
         ST_DONE: begin
            dp_cmd.load_rsp = !rsp_tvalid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rd_ff         <= '0;
         wr_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (dp_cmd.load_rsp) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (wr_ff == LastRow) begin
                  wr_ff    <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  wr_ff <= wr_ff + RowBits'(1);
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               case (dp_status.kind) inside
                  CMD_WRITE, CMD_READ: state_ff <= ST_CELL_RD;
                  CMD_STEP: begin
                     rd_ff    <= LastRow;
                     state_ff <= ST_G_PRIME;
                  end
                  default: state_ff <= ST_DONE;
               endcase
            end
            ST_CELL_RD:  state_ff <= ST_CELL_ACT;
            ST_CELL_ACT: state_ff <= ST_DONE;
            ST_G_PRIME: begin
               rd_ff    <= '0;
               state_ff <= ST_G_ABOVE;
            end
            ST_G_ABOVE: begin
               rd_ff    <= rd_ff + RowBits'(1);
               state_ff <= ST_G_CUR;
            end
            ST_G_CUR: begin
               rd_ff    <= rd_ff + RowBits'(1);
               wr_ff    <= '0;
               state_ff <= ST_G_SWEEP;
            end
            ST_G_SWEEP: begin
               wr_ff <= wr_ff + RowBits'(1);
               if (dp_cmd.rd_en) begin
                  rd_ff <= rd_ff + RowBits'(1);
               end
               if (wr_ff == PenultRow) begin
                  state_ff <= ST_G_LAST;
               end
            end
            ST_G_LAST: begin
               wr_ff    <= '0;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (dp_cmd.load_rsp) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rd_row     = rd_ff;
   assign wr_row     = wr_ff;

   `TLGS_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `TLGS_ASSERT_NEXT(a_rsp_loaded, dp_cmd.load_rsp, rsp_tvalid_ff)
   `TLGS_ASSERT_IMPL(a_sweep_range, state_ff == ST_G_SWEEP, wr_ff < LastRow)
   `TLGS_ASSERT_IMPL(a_last_row, state_ff == ST_G_LAST, wr_ff == LastRow)
   `TLGS_ASSERT_IMPL(a_no_rw_collision, dp_cmd.rd_en && dp_cmd.wr_en, rd_ff != wr_ff)

endmodule

### hw/rtl/tlgs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlgs_datapath
// Board RAM, item registers, three-row window and the row update logic.
// ----------------------------------------------------------------------------
module tlgs_datapath #(
   parameter int BOARD_WIDTH  = tlgs_pkg::BOARD_WIDTH_DEFAULT,
   parameter int BOARD_HEIGHT = tlgs_pkg::BOARD_HEIGHT_DEFAULT,
   localparam int RowBits = $clog2(BOARD_HEIGHT),
   localparam int ColBits = $clog2(BOARD_WIDTH)
) (
   input  logic                              clock,
   input  logic [tlgs_pkg::KIND_BITS-1:0]    req_cmd,
   input  logic [tlgs_pkg::COORD_BITS-1:0]   req_row,
   input  logic [tlgs_pkg::COORD_BITS-1:0]   req_col,
   input  logic                              req_cell_in,
   input  tlgs_pkg::dp_cmd_type              dp_cmd,
   output tlgs_pkg::dp_status_type           dp_status,
   input  logic [RowBits-1:0]                rd_row,
   input  logic [RowBits-1:0]                wr_row,
   output logic [tlgs_pkg::KIND_BITS-1:0]    rsp_done_kind,
   output logic                              rsp_cell_out
);
   import tlgs_pkg::*;

   logic [KIND_BITS-1:0]   kind_ff;
   logic [COORD_BITS-1:0]  row_ff;
   logic [COORD_BITS-1:0]  col_ff;
   logic                   cell_in_ff;
   logic                   cell_ff;
   logic [KIND_BITS-1:0]   rsp_kind_ff;
   logic                   rsp_cell_ff;
   logic [BOARD_WIDTH-1:0] above_ff;
   logic [BOARD_WIDTH-1:0] cur_ff;
   logic [BOARD_WIDTH-1:0] top_ff;

   logic                   on_board;
   logic [RowBits-1:0]     item_row;
   logic [ColBits-1:0]     col_idx;
   logic [BOARD_WIDTH-1:0] col_mask;
   logic [BOARD_WIDTH-1:0] below;
   logic [BOARD_WIDTH-1:0] gen_row;
   logic [BOARD_WIDTH-1:0] ram_wr_data;
   logic [BOARD_WIDTH-1:0] ram_rd_data;
   logic [RowBits-1:0]     ram_rd_addr;
   logic [RowBits-1:0]     ram_wr_addr;

   // one generation of a row; columns wrap around
   function automatic logic [BOARD_WIDTH-1:0] life_row(
      input logic [BOARD_WIDTH-1:0] up,
      input logic [BOARD_WIDTH-1:0] mid,
      input logic [BOARD_WIDTH-1:0] dn
   );
      logic [BOARD_WIDTH-1:0] res;
      logic [3:0]             n;
      int                     l;
      int                     r;
      res = '0;
      for (int c = 0; c < BOARD_WIDTH; c++) begin
         l = (c == 0) ? BOARD_WIDTH - 1 : c - 1;
         r = (c == BOARD_WIDTH - 1) ? 0 : c + 1;
         n = 4'(up[l]) + 4'(up[c]) + 4'(up[r]) + 4'(mid[l]) + 4'(mid[r])
           + 4'(dn[l]) + 4'(dn[c]) + 4'(dn[r]);
         res[c] = (n == BIRTH_COUNT) || (mid[c] && (n == KEEP_COUNT));
      end
      return res;
   endfunction

   assign on_board = (32'(row_ff) < 32'(BOARD_HEIGHT)) && (32'(col_ff) < 32'(BOARD_WIDTH));
   assign item_row = RowBits'(row_ff);
   assign col_idx  = ColBits'(col_ff);
   assign col_mask = BOARD_WIDTH'(1) << col_idx;
   assign below    = (dp_cmd.wr_sel == WR_GEN_TOP) ? top_ff : ram_rd_data;
   assign gen_row  = life_row(above_ff, cur_ff, below);

   always_comb begin
      case (dp_cmd.wr_sel) inside
         WR_ZERO: ram_wr_data = '0;
         WR_CELL: ram_wr_data = (ram_rd_data & ~col_mask) | (cell_in_ff ? col_mask : '0);
         WR_GEN_RAM, WR_GEN_TOP: ram_wr_data = gen_row;
         default: ram_wr_data = '0;
      endcase
   end

   assign ram_rd_addr = dp_cmd.rd_item ? item_row : rd_row;
   assign ram_wr_addr = dp_cmd.wr_item ? item_row : wr_row;

   tlgs_ram #(
      .WIDTH (BOARD_WIDTH),
      .DEPTH (BOARD_HEIGHT)
   ) u_board (
      .clock   (clock),
      .wr_en   (dp_cmd.wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (dp_cmd.rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         kind_ff    <= req_cmd;
         row_ff     <= req_row;
         col_ff     <= req_col;
         cell_in_ff <= req_cell_in;
         cell_ff    <= 1'b0;
      end
      if (dp_cmd.take_cell) begin
         cell_ff <= (kind_ff == CMD_READ) && on_board && ram_rd_data[col_idx];
      end
      if (dp_cmd.load_above) begin
         above_ff <= ram_rd_data;
      end
      if (dp_cmd.load_cur) begin
         cur_ff <= ram_rd_data;
         top_ff <= ram_rd_data;
      end
      if (dp_cmd.shift) begin
         above_ff <= cur_ff;
         cur_ff   <= ram_rd_data;
      end
      if (dp_cmd.load_rsp) begin
         rsp_kind_ff <= kind_ff;
         rsp_cell_ff <= cell_ff;
      end
   end

   assign dp_status.kind     = kind_ff;
   assign dp_status.on_board = on_board;
   assign rsp_done_kind      = rsp_kind_ff;
   assign rsp_cell_out       = rsp_cell_ff;

endmodule

### hw/rtl/toroidal_life_generation_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_life_generation_step_core
// Toroidal Conway life board: cell write, cell read and generation step.
// ----------------------------------------------------------------------------
// Cell write or read: dispatch, cell read, cell act, then the result loads;
// unused command: dispatch, then the result. Generation: the result is set
// by the sweep through the board RAM (one read, one write port) at one row
// per cycle. One word in work at a time; the next is taken the cycle after
// the result loads, later while rsp_tready holds back the last response.
// Synchronous reset; the board is then zeroed row by row.
module toroidal_life_generation_step_core #(
   parameter int BOARD_WIDTH  = tlgs_pkg::BOARD_WIDTH_DEFAULT,
   parameter int BOARD_HEIGHT = tlgs_pkg::BOARD_HEIGHT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tlgs_pkg::REQ_DATA_BITS-1:0]  req_tdata,  // row, col, cell_in
   input  logic [tlgs_pkg::KIND_BITS-1:0]      req_tuser,  // cmd
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tlgs_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,  // cell_out
   output logic [tlgs_pkg::KIND_BITS-1:0]      rsp_tuser   // done_kind
);
   import tlgs_pkg::*;

   localparam int RowBits = $clog2(BOARD_HEIGHT);

   dp_cmd_type         dp_cmd;
   dp_status_type      dp_status;
   logic [RowBits-1:0] rd_row;
   logic [RowBits-1:0] wr_row;
   logic               cell_out;

   tlgs_ctrl #(
      .BOARD_HEIGHT (BOARD_HEIGHT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd),
      .rd_row     (rd_row),
      .wr_row     (wr_row)
   );

   tlgs_datapath #(
      .BOARD_WIDTH  (BOARD_WIDTH),
      .BOARD_HEIGHT (BOARD_HEIGHT)
   ) u_datapath (
      .clock         (clock),
      .req_cmd       (req_tuser),
      .req_row       (req_tdata[COORD_BITS-1:0]),
      .req_col       (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .req_cell_in   (req_tdata[2*COORD_BITS]),
      .dp_cmd        (dp_cmd),
      .dp_status     (dp_status),
      .rd_row        (rd_row),
      .wr_row        (wr_row),
      .rsp_done_kind (rsp_tuser),
      .rsp_cell_out  (cell_out)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS-1){1'b0}}, cell_out};

endmodule
